### rtl/uvsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsc_pkg
// Shared constants, tables and types of the UV sphere cell vertex unit.
// ----------------------------------------------------------------------------
package uvsc_pkg;

	// Field widths and configuration limits.
	localparam int MAX_SUBDIVISION = 256;
	localparam int FRAC_BITS       = 14;
	localparam int CFG_W           = 9;
	localparam int IDX_W           = 8;
	localparam int POS_W           = 16;
	localparam int TEX_W           = 17;
	localparam int CORNER_W        = 3;
	localparam logic [CFG_W-1:0] RESET_SUBDIVISION = 9'd16;

	// Corner sequencing.
	localparam logic [CORNER_W-1:0] FIRST_CORNER = 3'd0;
	localparam logic [CORNER_W-1:0] LAST_CORNER  = 3'd5;

	// Long division of k * 2^32 by the subdivision count.
	localparam int K_W        = CFG_W;
	localparam int FRAC_DIV   = 32;
	localparam int DIV_STEPS  = K_W + FRAC_DIV;
	localparam int DIV_SPS    = 4;
	localparam int DIV_STAGES = (DIV_STEPS + DIV_SPS - 1) / DIV_SPS;
	localparam int Q_W        = FRAC_DIV + 1;

	// Texture coordinates are Q1.16.
	localparam int TEX_FRAC  = 16;
	localparam int TEX_SHIFT = FRAC_DIV - TEX_FRAC;
	localparam logic [TEX_W-1:0] UV_ONE = TEX_W'(1 << TEX_FRAC);

	// Phase and CORDIC datapath.
	localparam int PH_W          = 32;
	localparam int TRIG_W        = 32;
	localparam int CW            = 34;
	localparam int CORDIC_STEPS  = 28;
	localparam int CORDIC_SPS    = 2;
	localparam int CORDIC_STAGES = (CORDIC_STEPS + CORDIC_SPS - 1) / CORDIC_SPS;
	localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
	localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

	// Products and rounding.
	localparam int PROD_W = 2 * TRIG_W;
	localparam int POS_SH = 2 * (TRIG_W - 2) - FRAC_BITS;
	localparam int Y_SH   = (TRIG_W - 2) - FRAC_BITS;

	// Arctangent of 2^-k in phase units (2^32 per turn).
	function automatic logic signed [CW-1:0] atan_turn(input int k);
		logic signed [CW-1:0] v;
		case (k)
			0:       v = 34'sd536870912;
			1:       v = 34'sd316933406;
			2:       v = 34'sd167458907;
			3:       v = 34'sd85004756;
			4:       v = 34'sd42667331;
			5:       v = 34'sd21354465;
			6:       v = 34'sd10679838;
			7:       v = 34'sd5340245;
			8:       v = 34'sd2670163;
			9:       v = 34'sd1335087;
			10:      v = 34'sd667544;
			11:      v = 34'sd333772;
			12:      v = 34'sd166886;
			13:      v = 34'sd83443;
			14:      v = 34'sd41722;
			15:      v = 34'sd20861;
			16:      v = 34'sd10430;
			17:      v = 34'sd5215;
			18:      v = 34'sd2608;
			19:      v = 34'sd1304;
			20:      v = 34'sd652;
			21:      v = 34'sd326;
			22:      v = 34'sd163;
			23:      v = 34'sd81;
			24:      v = 34'sd41;
			25:      v = 34'sd20;
			26:      v = 34'sd10;
			27:      v = 34'sd5;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Upper latitude for corners one, three and four.
	function automatic logic corner_lat(input logic [CORNER_W-1:0] c);
		return c inside {3'd1, 3'd3, 3'd4};
	endfunction

	// Upper longitude for corners two, four and five.
	function automatic logic corner_lon(input logic [CORNER_W-1:0] c);
		return c inside {3'd2, 3'd4, 3'd5};
	endfunction

	// One cell's finished results, indexed by {lat, lon} where both apply.
	typedef struct packed {
		logic                        err;
		logic [3:0][POS_W-1:0]       px;
		logic [3:0][POS_W-1:0]       pz;
		logic [1:0][POS_W-1:0]       py;
		logic [1:0][TEX_W-1:0]       tu;
		logic [1:0][TEX_W-1:0]       tv;
	} uvsc_item_t;

endpackage
`default_nettype wire

### rtl/uvsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsc_div
// Pipelined restoring divider: floor(k * 2^32 / n) and its remainder.
// ----------------------------------------------------------------------------
module uvsc_div (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [uvsc_pkg::K_W-1:0] num_k,
	input  wire logic [uvsc_pkg::CFG_W-1:0] den,
	output logic      [uvsc_pkg::Q_W-1:0] quo,
	output logic      [uvsc_pkg::K_W-1:0] rem
);
	import uvsc_pkg::*;

	logic [K_W-1:0]       rem_s [DIV_STAGES];
	logic [Q_W-1:0]       quo_s [DIV_STAGES];
	logic [DIV_STEPS-1:0] num_s [DIV_STAGES];

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic [K_W-1:0]       r_in;
		logic [Q_W-1:0]       q_in;
		logic [DIV_STEPS-1:0] n_in;
		logic [K_W-1:0]       r_nx;
		logic [Q_W-1:0]       q_nx;
		logic [DIV_STEPS-1:0] n_nx;

		// Stage inputs: the first stage starts from the numerator.
		if (s == 0) begin : g_first
			assign r_in = '0;
			assign q_in = '0;
			assign n_in = {num_k, {FRAC_DIV{1'b0}}};
		end else begin : g_next
			assign r_in = rem_s[s-1];
			assign q_in = quo_s[s-1];
			assign n_in = num_s[s-1];
		end

		// A few quotient bits per stage, one compare and subtract each.
		always_comb begin
			logic [K_W:0] trial;
			trial = '0;
			r_nx  = r_in;
			q_nx  = q_in;
			n_nx  = n_in;
			for (int m = 0; m < DIV_SPS; m++) begin
				if (s * DIV_SPS + m < DIV_STEPS) begin
					trial = {r_nx, n_nx[DIV_STEPS-1]};
					n_nx  = {n_nx[DIV_STEPS-2:0], 1'b0};
					if (trial >= {1'b0, den}) begin
						r_nx = K_W'(trial - {1'b0, den});
						q_nx = {q_nx[Q_W-2:0], 1'b1};
					end else begin
						r_nx = trial[K_W-1:0];
						q_nx = {q_nx[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s] <= r_nx;
				quo_s[s] <= q_nx;
				num_s[s] <= n_nx;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];
	assign rem = rem_s[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/uvsc_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsc_cordic
// Pipelined rotation-mode CORDIC giving cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
module uvsc_cordic (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [uvsc_pkg::PH_W-1:0]   phase,
	output logic signed      [uvsc_pkg::TRIG_W-1:0] cos_o,
	output logic signed      [uvsc_pkg::TRIG_W-1:0] sin_o
);
	import uvsc_pkg::*;

	logic signed [CW-1:0] x_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] z_s [CORDIC_STAGES+1];
	logic                 flip_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] ph_ext;
	logic signed [CW-1:0] z_init;
	logic                 flip_init;

	// Fold the phase into the right half plane; cosine is negated later.
	assign ph_ext = CW'(phase);
	always_comb begin
		flip_init = 1'b0;
		z_init    = ph_ext;
		if (ph_ext > QUARTER_TURN) begin
			z_init    = HALF_TURN - ph_ext;
			flip_init = 1'b1;
		end else if (ph_ext < -QUARTER_TURN) begin
			z_init    = -HALF_TURN - ph_ext;
			flip_init = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= z_init;
			flip_s[0] <= flip_init;
		end
	end

	for (genvar s = 1; s <= CORDIC_STAGES; s++) begin : g_stage
		logic signed [CW-1:0] x_nx;
		logic signed [CW-1:0] y_nx;
		logic signed [CW-1:0] z_nx;

		// Two micro-rotations per stage.
		always_comb begin
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			int                   k;
			x_nx = x_s[s-1];
			y_nx = y_s[s-1];
			z_nx = z_s[s-1];
			dx   = '0;
			dy   = '0;
			for (int m = 0; m < CORDIC_SPS; m++) begin
				k = (s - 1) * CORDIC_SPS + m;
				if (k < CORDIC_STEPS) begin
					dx = y_nx >>> k;
					dy = x_nx >>> k;
					if (!z_nx[CW-1]) begin
						x_nx = x_nx - dx;
						y_nx = y_nx + dy;
						z_nx = z_nx - atan_turn(k);
					end else begin
						x_nx = x_nx + dx;
						y_nx = y_nx - dy;
						z_nx = z_nx + atan_turn(k);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[s]    <= x_nx;
				y_s[s]    <= y_nx;
				z_s[s]    <= z_nx;
				flip_s[s] <= flip_s[s-1];
			end
		end
	end

	// Undo the fold and register the results.
	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= flip_s[CORDIC_STAGES] ? TRIG_W'(-x_s[CORDIC_STAGES])
				: TRIG_W'(x_s[CORDIC_STAGES]);
			sin_o <= TRIG_W'(y_s[CORDIC_STAGES]);
		end
	end

endmodule
`default_nettype wire

### rtl/uvsc_ser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsc_ser
// Output stage: holds one finished cell and sends its vertices one beat each.
// ----------------------------------------------------------------------------
module uvsc_ser (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load_valid,
	input  wire uvsc_pkg::uvsc_item_t             load_item,
	output logic                                  adv,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [uvsc_pkg::POS_W-1:0]     pos_x,
	output logic signed [uvsc_pkg::POS_W-1:0]     pos_y,
	output logic signed [uvsc_pkg::POS_W-1:0]     pos_z,
	output logic        [uvsc_pkg::TEX_W-1:0]     tex_u,
	output logic        [uvsc_pkg::TEX_W-1:0]     tex_v,
	output logic        [uvsc_pkg::CORNER_W-1:0]  corner,
	output logic                                  last,
	output logic                                  index_error
);
	import uvsc_pkg::*;

	logic                busy_q;
	logic [CORNER_W-1:0] cnt_q;
	uvsc_item_t          item_q;
	logic                fire;
	logic                last_beat;
	logic                la;
	logic                lo;

	// A new cell loads when the stage is empty or sends its final beat.
	assign fire      = busy_q && !out_stall;
	assign last_beat = item_q.err || (cnt_q == LAST_CORNER);
	assign adv       = !busy_q || (fire && last_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= FIRST_CORNER;
		end else if (adv) begin
			busy_q <= load_valid;
			cnt_q  <= FIRST_CORNER;
		end else if (fire) begin
			cnt_q  <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= load_item;
		end
	end

	// Pick the latitude and longitude halves for the current corner.
	assign la = corner_lat(cnt_q);
	assign lo = corner_lon(cnt_q);

	always_comb begin
		out_valid = busy_q;
		if (item_q.err) begin
			pos_x       = '0;
			pos_y       = '0;
			pos_z       = '0;
			tex_u       = '0;
			tex_v       = '0;
			corner      = FIRST_CORNER;
			last        = 1'b1;
			index_error = 1'b1;
		end else begin
			pos_x       = $signed(item_q.px[{la, lo}]);
			pos_y       = $signed(item_q.py[la]);
			pos_z       = $signed(item_q.pz[{la, lo}]);
			tex_u       = item_q.tu[lo];
			tex_v       = item_q.tv[la];
			corner      = cnt_q;
			last        = (cnt_q == LAST_CORNER);
			index_error = 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/uv_sphere_cell_vertices_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_cell_vertices_unit
// Turns one sphere cell index pair into the cell's six triangle vertices.
// ----------------------------------------------------------------------------
// The input is accepted, and the whole pipeline advances, only while the output
// stage is empty or sending a cell's final beat; each cell gives six beats, and
// an out-of-range cell gives a single beat.
// The divider (11 stages) and CORDIC (16 stages) run fully pipelined.
// Reset: asynchronous, active low; clears valid bits and sets subdivision to 16.
module uv_sphere_cell_vertices_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [uvsc_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [uvsc_pkg::IDX_W-1:0]          lat_index,
	input  wire logic [uvsc_pkg::IDX_W-1:0]          lon_index,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [uvsc_pkg::POS_W-1:0]        pos_x,
	output logic signed [uvsc_pkg::POS_W-1:0]        pos_y,
	output logic signed [uvsc_pkg::POS_W-1:0]        pos_z,
	output logic        [uvsc_pkg::TEX_W-1:0]        tex_u,
	output logic        [uvsc_pkg::TEX_W-1:0]        tex_v,
	output logic        [uvsc_pkg::CORNER_W-1:0]     corner,
	output logic                                     last,
	output logic                                     index_error
);
	import uvsc_pkg::*;

	logic [CFG_W-1:0] subdiv_q;
	logic [CFG_W-1:0] n_sat;
	logic             adv;

	// Configuration register, always ready.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= RESET_SUBDIVISION;
		end else if (cfg_valid && cfg_ready) begin
			subdiv_q <= cfg_data;
		end
	end

	assign n_sat    = (int'(subdiv_q) > MAX_SUBDIVISION) ? CFG_W'(MAX_SUBDIVISION) : subdiv_q;
	assign in_stall = !adv;

	// Stage 1: range check and the four division numerators.
	logic           v_s1;
	logic           err_s1;
	logic [K_W-1:0] k_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= (n_sat == '0) || (K_W'(lat_index) >= n_sat)
				|| (K_W'(lon_index) >= n_sat);
			k_s1[0] <= K_W'(lat_index);
			k_s1[1] <= K_W'(lat_index) + 9'd1;
			k_s1[2] <= K_W'(lon_index);
			k_s1[3] <= K_W'(lon_index) + 9'd1;
		end
	end

	// Dividers: lanes 0 and 1 for latitude, 2 and 3 for longitude.
	logic [Q_W-1:0] quo [4];
	logic [K_W-1:0] rem_lon [2];

	uvsc_div u_div_lat0 (.clk(clk), .en(adv), .num_k(k_s1[0]), .den(n_sat),
		.quo(quo[0]), .rem());
	uvsc_div u_div_lat1 (.clk(clk), .en(adv), .num_k(k_s1[1]), .den(n_sat),
		.quo(quo[1]), .rem());
	uvsc_div u_div_lon0 (.clk(clk), .en(adv), .num_k(k_s1[2]), .den(n_sat),
		.quo(quo[2]), .rem(rem_lon[0]));
	uvsc_div u_div_lon1 (.clk(clk), .en(adv), .num_k(k_s1[3]), .den(n_sat),
		.quo(quo[3]), .rem(rem_lon[1]));

	// Valid and error bits alongside the divider.
	logic dv_q   [DIV_STAGES];
	logic derr_q [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIV_STAGES; d++) begin
				dv_q[d] <= 1'b0;
			end
		end else if (adv) begin
			dv_q[0] <= v_s1;
			for (int d = 1; d < DIV_STAGES; d++) begin
				dv_q[d] <= dv_q[d-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			derr_q[0] <= err_s1;
			for (int d = 1; d < DIV_STAGES; d++) begin
				derr_q[d] <= derr_q[d-1];
			end
		end
	end

	// Stage 2: phases and texture coordinates from the quotients.
	logic                   v_s2;
	logic                   err_s2;
	logic signed [PH_W-1:0] lat_ph_s2 [2];
	logic signed [PH_W-1:0] lon_ph_s2 [2];
	logic [TEX_W-1:0]       tu_s2 [2];
	logic [TEX_W-1:0]       tv_s2 [2];
	logic [PH_W-1:0]        lat_ph [2];
	logic [PH_W-1:0]        lon_ph [2];
	logic [TEX_W-1:0]       tu [2];
	logic [TEX_W-1:0]       tv [2];

	always_comb begin
		logic [Q_W:0] half;
		logic [Q_W:0] rb;
		half = '0;
		rb   = '0;
		for (int a = 0; a < 2; a++) begin
			// Latitude: halve the 2^32 quotient with rounding, offset by a quarter turn.
			half      = ({1'b0, quo[a]} + (Q_W+1)'(1)) >> 1;
			lat_ph[a] = PH_W'(half) - PH_W'(QUARTER_TURN);
			tv[a]     = UV_ONE - TEX_W'(({1'b0, quo[a]}
				+ (Q_W+1)'(1 << (TEX_SHIFT - 1))) >> TEX_SHIFT);
			// Longitude: round on the remainder, wrap to one turn.
			rb        = (Q_W+1)'({rem_lon[a], 1'b0} >= {1'b0, n_sat});
			lon_ph[a] = PH_W'({1'b0, quo[a+2]} + rb);
			tu[a]     = TEX_W'(({1'b0, quo[a+2]}
				+ (Q_W+1)'(1 << (TEX_SHIFT - 1))) >> TEX_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= dv_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2 <= derr_q[DIV_STAGES-1];
			for (int a = 0; a < 2; a++) begin
				lat_ph_s2[a] <= $signed(lat_ph[a]);
				lon_ph_s2[a] <= $signed(lon_ph[a]);
				tu_s2[a]     <= tu[a];
				tv_s2[a]     <= tv[a];
			end
		end
	end

	// Sine and cosine of the two latitudes and two longitudes.
	logic signed [TRIG_W-1:0] clat [2];
	logic signed [TRIG_W-1:0] slat [2];
	logic signed [TRIG_W-1:0] clon [2];
	logic signed [TRIG_W-1:0] slon [2];

	uvsc_cordic u_cordic_lat0 (.clk(clk), .en(adv), .phase(lat_ph_s2[0]),
		.cos_o(clat[0]), .sin_o(slat[0]));
	uvsc_cordic u_cordic_lat1 (.clk(clk), .en(adv), .phase(lat_ph_s2[1]),
		.cos_o(clat[1]), .sin_o(slat[1]));
	uvsc_cordic u_cordic_lon0 (.clk(clk), .en(adv), .phase(lon_ph_s2[0]),
		.cos_o(clon[0]), .sin_o(slon[0]));
	uvsc_cordic u_cordic_lon1 (.clk(clk), .en(adv), .phase(lon_ph_s2[1]),
		.cos_o(clon[1]), .sin_o(slon[1]));

	// Valid, error and texture values alongside the CORDIC.
	logic                   cv_q   [CORDIC_LAT];
	logic                   cerr_q [CORDIC_LAT];
	logic [1:0][TEX_W-1:0]  ctu_q  [CORDIC_LAT];
	logic [1:0][TEX_W-1:0]  ctv_q  [CORDIC_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < CORDIC_LAT; d++) begin
				cv_q[d] <= 1'b0;
			end
		end else if (adv) begin
			cv_q[0] <= v_s2;
			for (int d = 1; d < CORDIC_LAT; d++) begin
				cv_q[d] <= cv_q[d-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cerr_q[0] <= err_s2;
			ctu_q[0]  <= {tu_s2[1], tu_s2[0]};
			ctv_q[0]  <= {tv_s2[1], tv_s2[0]};
			for (int d = 1; d < CORDIC_LAT; d++) begin
				cerr_q[d] <= cerr_q[d-1];
				ctu_q[d]  <= ctu_q[d-1];
				ctv_q[d]  <= ctv_q[d-1];
			end
		end
	end

	// Stage 3: the eight position products, indexed by {lat, lon}.
	logic                     v_s3;
	logic                     err_s3;
	logic signed [PROD_W-1:0] px_s3 [4];
	logic signed [PROD_W-1:0] pz_s3 [4];
	logic signed [TRIG_W-1:0] sy_s3 [2];
	logic [1:0][TEX_W-1:0]    tu_s3;
	logic [1:0][TEX_W-1:0]    tv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= cv_q[CORDIC_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s3   <= cerr_q[CORDIC_LAT-1];
			tu_s3    <= ctu_q[CORDIC_LAT-1];
			tv_s3    <= ctv_q[CORDIC_LAT-1];
			px_s3[0] <= clat[0] * clon[0];
			px_s3[1] <= clat[0] * clon[1];
			px_s3[2] <= clat[1] * clon[0];
			px_s3[3] <= clat[1] * clon[1];
			pz_s3[0] <= clat[0] * slon[0];
			pz_s3[1] <= clat[0] * slon[1];
			pz_s3[2] <= clat[1] * slon[0];
			pz_s3[3] <= clat[1] * slon[1];
			sy_s3[0] <= slat[0];
			sy_s3[1] <= slat[1];
		end
	end

	// Round half up at the given bit and clamp to plus or minus one.
	function automatic logic [POS_W-1:0] round_sat(input logic signed [PROD_W:0] v,
		input int sh);
		logic signed [PROD_W:0] r;
		logic signed [PROD_W:0] lim;
		logic [POS_W-1:0]       res;
		r   = (v + ((PROD_W+1)'(1) <<< (sh - 1))) >>> sh;
		lim = (PROD_W+1)'(1) <<< FRAC_BITS;
		if (r > lim) begin
			res = POS_W'(lim);
		end else if (r < -lim) begin
			res = POS_W'(-lim);
		end else begin
			res = POS_W'(r);
		end
		return res;
	endfunction

	// Stage 4: rounding and saturation into the finished cell.
	logic       v_s4;
	uvsc_item_t item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s4.err <= err_s3;
			item_s4.tu  <= tu_s3;
			item_s4.tv  <= tv_s3;
			for (int c = 0; c < 4; c++) begin
				item_s4.px[c] <= round_sat((PROD_W+1)'(px_s3[c]), POS_SH);
				item_s4.pz[c] <= round_sat((PROD_W+1)'(pz_s3[c]), POS_SH);
			end
			for (int a = 0; a < 2; a++) begin
				item_s4.py[a] <= round_sat((PROD_W+1)'(sy_s3[a]), Y_SH);
			end
		end
	end

	// Output stage.
	uvsc_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s4),
		.load_item  (item_s4),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.tex_u      (tex_u),
		.tex_v      (tex_v),
		.corner     (corner),
		.last       (last),
		.index_error(index_error)
	);

endmodule
`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UV sphere cell vertex unit. Cells are driven
// from a queue under several idle and stall phases. Each accepted cell's six
// vertices (one error vertex if out of range) come from a behavioral CORDIC
// model; every output beat is compared field by field to the oldest of them.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import uvsc_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] lat;
		logic [IDX_W-1:0] lon;
	} cell_t;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic [TEX_W-1:0]        tu;
		logic [TEX_W-1:0]        tv;
		logic [CORNER_W-1:0]     cor;
		logic                    lst;
		logic                    err;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic cfg_ready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [IDX_W-1:0] lat_index = '0;
	logic [IDX_W-1:0] lon_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [TEX_W-1:0] tex_u, tex_v;
	logic [CORNER_W-1:0] corner;
	logic last, index_error;

	cell_t   cell_queue[$];
	vertex_t vertex_queue[$];
	int      fail_count = 0;
	int      sender_idle_pct = 0;
	int      receiver_stall_pct = 0;
	logic [CFG_W-1:0] cur_subdiv = RESET_SUBDIVISION;

	uv_sphere_cell_vertices_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.lat_index(lat_index), .lon_index(lon_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v), .corner(corner),
		.last(last), .index_error(index_error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Arctangent of 2^-k in phase units, 2^32 per turn.
	function automatic longint atan_step(input int k);
		longint tbl[28] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
			20, 10, 5};
		return tbl[k];
	endfunction

	// Arithmetic right shift is a floor shift on signed longints.
	function automatic void phase_sincos(input longint phase, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		bit mirror;
		x = 652032874;
		y = 0;
		mirror = 1'b0;
		if (phase > 64'sd1073741824) begin
			phase = 64'sd2147483648 - phase;
			mirror = 1'b1;
		end else if (phase < -64'sd1073741824) begin
			phase = -64'sd2147483648 - phase;
			mirror = 1'b1;
		end
		z = phase;
		for (int k = 0; k < 28; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(k);
			end else begin
				x += dx; y -= dy; z += atan_step(k);
			end
		end
		c = mirror ? -x : x;
		s = y;
	endfunction

	// Round half up by a right shift, then clamp to plus or minus one.
	function automatic logic signed [POS_W-1:0] clamp_pos(input longint v, input int sh);
		longint r, lim;
		lim = 64'sd1 << FRAC_BITS;
		r = (v + (64'sd1 << (sh - 1))) >>> sh;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[POS_W-1:0];
	endfunction

	// Products of two Q1.30 values need 62 bits plus sign; widen to 128.
	function automatic longint round_product(input longint a, input longint b);
		logic signed [127:0] p;
		p = 128'(signed'(a)) * 128'(signed'(b));
		p = (p + (128'sd1 << (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
		return longint'(p);
	endfunction

	function automatic logic [TEX_W-1:0] tex_frac(input longint k, input longint n);
		return TEX_W'((k * 65536 + n / 2) / n);
	endfunction

	// Expected vertices of one cell under the current subdivision.
	task automatic predict_cell_vertices(input cell_t cl);
		longint n, li, lj, lat_ph, lon_ph;
		longint clat[2], slat[2], clon[2], slon[2];
		logic [TEX_W-1:0] tu[2], tv[2];
		vertex_t v;
		int la, lo;
		n = cur_subdiv;
		if (n > MAX_SUBDIVISION) n = MAX_SUBDIVISION;
		if (n == 0 || cl.lat >= n || cl.lon >= n) begin
			v = '0;
			v.lst = 1'b1;
			v.err = 1'b1;
			vertex_queue.push_back(v);
			return;
		end
		for (int a = 0; a < 2; a++) begin
			li = cl.lat + a;
			lj = cl.lon + a;
			lat_ph = -64'sd1073741824 + (li * 64'sd2147483648 + n / 2) / n;
			lon_ph = ((lj << 32) + n / 2) / n;
			lon_ph = lon_ph & 64'hFFFF_FFFF;
			if (lon_ph >= 64'sd2147483648) lon_ph -= 64'sd4294967296;
			phase_sincos(lat_ph, clat[a], slat[a]);
			phase_sincos(lon_ph, clon[a], slon[a]);
			tu[a] = tex_frac(lj, n);
			tv[a] = TEX_W'(65536) - tex_frac(li, n);
		end
		for (int r = 0; r < 6; r++) begin
			la = corner_lat(3'(r));
			lo = corner_lon(3'(r));
			v.px = clamp_pos(round_product(clat[la], clon[lo]) * 2, 1);
			v.py = clamp_pos(slat[la], 30 - FRAC_BITS);
			v.pz = clamp_pos(round_product(clat[la], slon[lo]) * 2, 1);
			v.tu = tu[lo];
			v.tv = tv[la];
			v.cor = 3'(r);
			v.lst = (r == 5);
			v.err = 1'b0;
			vertex_queue.push_back(v);
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Driver: presents queued cells, holding a stalled beat steady.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_cell_vertices('{lat: lat_index, lon: lon_index});
		end
		if (!in_valid || !in_stall) begin
			if (cell_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				cell_t c;
				c = cell_queue.pop_front();
				in_valid <= 1'b1;
				lat_index <= c.lat;
				lon_index <= c.lon;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each output beat and draws a random stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_queue.size() == 0) begin
				report_mismatch("unexpected beat, corner", corner, -1);
			end else begin
				vertex_t w;
				w = vertex_queue.pop_front();
				if (pos_x !== w.px) report_mismatch("pos_x", pos_x, w.px);
				if (pos_y !== w.py) report_mismatch("pos_y", pos_y, w.py);
				if (pos_z !== w.pz) report_mismatch("pos_z", pos_z, w.pz);
				if (tex_u !== w.tu) report_mismatch("tex_u", tex_u, w.tu);
				if (tex_v !== w.tv) report_mismatch("tex_v", tex_v, w.tv);
				if (corner !== w.cor) report_mismatch("corner", corner, w.cor);
				if (last !== w.lst) report_mismatch("last", last, w.lst);
				if (index_error !== w.err)
					report_mismatch("index_error", index_error, w.err);
			end
		end
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Wait until the block has drained every predicted vertex. The check runs
	// at the falling edge, after the driver's updates have settled.
	task automatic wait_drained();
		do @(negedge clk);
		while (cell_queue.size() > 0 || in_valid || vertex_queue.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_subdivision(input logic [CFG_W-1:0] n);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_subdiv = n;
	endtask

	task automatic queue_random_cells(input int count, input int n);
		cell_t c;
		int span;
		span = (n < 1) ? 1 : ((n > 256) ? 256 : n);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0) begin
				c.lat = IDX_W'($urandom);
				c.lon = IDX_W'($urandom);
			end else begin
				c.lat = IDX_W'($urandom_range(span - 1));
				c.lon = IDX_W'($urandom_range(span - 1));
			end
			cell_queue.push_back(c);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells at the reset subdivision: poles, seams, and out of range.
		cell_queue.push_back('{lat: 8'd0, lon: 8'd0});
		cell_queue.push_back('{lat: 8'd15, lon: 8'd15});
		cell_queue.push_back('{lat: 8'd7, lon: 8'd8});
		cell_queue.push_back('{lat: 8'd16, lon: 8'd0});
		cell_queue.push_back('{lat: 8'd0, lon: 8'd16});
		cell_queue.push_back('{lat: 8'd255, lon: 8'd255});
		cell_queue.push_back('{lat: 8'd3, lon: 8'd12});
		wait_drained();

		// Largest legal subdivision reaches every index bit.
		write_subdivision(9'd256);
		cell_queue.push_back('{lat: 8'd255, lon: 8'd255});
		cell_queue.push_back('{lat: 8'd128, lon: 8'd127});
		cell_queue.push_back('{lat: 8'd0, lon: 8'd255});
		cell_queue.push_back('{lat: 8'hAA, lon: 8'h55});
		wait_drained();

		// Subdivision one, zero (all errors) and above the maximum.
		write_subdivision(9'd1);
		cell_queue.push_back('{lat: 8'd0, lon: 8'd0});
		cell_queue.push_back('{lat: 8'd1, lon: 8'd0});
		wait_drained();
		write_subdivision(9'd0);
		cell_queue.push_back('{lat: 8'd0, lon: 8'd0});
		wait_drained();
		write_subdivision(9'd511);
		cell_queue.push_back('{lat: 8'd255, lon: 8'd0});
		cell_queue.push_back('{lat: 8'd1, lon: 8'd254});
		wait_drained();

		// Random phases: free flow, idle sender, stalling receiver, both.
		for (int ph = 0; ph < 4; ph++) begin
			logic [CFG_W-1:0] n;
			n = (ph == 0) ? 9'd2 : ((ph == 3) ? 9'd256 : 9'($urandom_range(3, 255)));
			write_subdivision(n);
			sender_idle_pct = (ph == 1 || ph == 3) ? 76 : 0;
			receiver_stall_pct = (ph == 2 || ph == 3) ? 76 : 0;
			if (ph == 3) begin
				sender_idle_pct = 8;
				receiver_stall_pct = 8;
			end
			queue_random_cells(70, int'(n));
			wait_drained();
		end
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		write_subdivision(9'($urandom_range(300, 511)));
		queue_random_cells(20, 256);
		wait_drained();

		if (fail_count == 0 && vertex_queue.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb NOT OK");
		$finish;
	end
endmodule

### files.f
rtl/uvsc_pkg.sv
rtl/uvsc_div.sv
rtl/uvsc_cordic.sv
rtl/uvsc_ser.sv
rtl/uv_sphere_cell_vertices_unit.sv
test/tb.sv
